// ===== hdl/bums_pkg.sv =====
// ----------------------------------------------------------------------------
// bums_pkg
// Shared types and constants of the bottom-up merge sorter: data width,
// sequencer states and the control group from sequencer to datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bums_pkg;

   localparam int DATA_W = 32;

   typedef logic signed [DATA_W-1:0] data_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_PASS,
      ST_RUN,
      ST_READ,
      ST_MERGE,
      ST_EMIT_READ,
      ST_EMIT_PUT
   } bums_state_type;

   typedef struct packed {
      logic wr_a;
      logic wr_b;
      logic rd_sel_b;
      logic emit;
      logic end_of_set;
      logic overflow;
   } bums_ctrl_type;

endpackage

`default_nettype wire

// ===== hdl/bums_ram.sv =====
// ----------------------------------------------------------------------------
// bums_ram
// Element buffer: one write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bums_ram
   import bums_pkg::*;
#(
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire data_type                 wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr0,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr1,
   output data_type                      rd_data0,
   output data_type                      rd_data1
);

   data_type mem [DEPTH];
   data_type rd_data0_ff;
   data_type rd_data1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data0_ff <= mem[rd_addr0];
      rd_data1_ff <= mem[rd_addr1];
   end

   assign rd_data0 = rd_data0_ff;
   assign rd_data1 = rd_data1_ff;

endmodule

`default_nettype wire

// ===== hdl/bums_sequencer.sv =====
// ----------------------------------------------------------------------------
// bums_sequencer
// Load, merge-pass and emit sequencer with the shared signed compare unit.
// Passes ping-pong between buffer a and buffer b.
// ----------------------------------------------------------------------------
`default_nettype none

module bums_sequencer
   import bums_pkg::*;
#(
   parameter int SIZE = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire data_type                req_value,
   input  wire logic                    req_last,
   output logic                         req_stall,
   input  wire logic                    out_free,
   input  wire data_type                rd_left,
   input  wire data_type                rd_right,
   output logic [$clog2(SIZE)-1:0]      rd_addr0,
   output logic [$clog2(SIZE)-1:0]      rd_addr1,
   output logic [$clog2(SIZE)-1:0]      wr_addr,
   output data_type                     wr_data,
   output bums_ctrl_type                ctrl
);

   localparam int AW = $clog2(SIZE);
   localparam int CW = $clog2(SIZE + 1);
   localparam int PW = CW + 2;

   bums_state_type state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           dropped_ff, dropped_in;
   logic           sel_ff, sel_in;
   logic [PW-1:0]  width_ff, width_in;
   logic [PW-1:0]  lo_ff, lo_in;
   logic [PW-1:0]  mid_ff, mid_in;
   logic [PW-1:0]  hi_ff, hi_in;
   logic [PW-1:0]  i_ff, i_in;
   logic [PW-1:0]  j_ff, j_in;
   logic [PW-1:0]  k_ff, k_in;

   logic           accept;
   logic           room;
   logic [PW-1:0]  n_ext;
   logic [PW-1:0]  lo_w;
   logic [PW-1:0]  lo_2w;
   logic           take_left;
   logic           run_done;
   logic           set_done;

   assign accept    = req_valid && (state_ff == ST_LOAD);
   assign room      = count_ff < CW'(SIZE);
   assign n_ext     = PW'(count_ff);
   assign lo_w      = lo_ff + width_ff;
   assign lo_2w     = lo_ff + (width_ff << 1);
   assign take_left = (i_ff < mid_ff) && ((j_ff >= hi_ff) || (rd_left <= rd_right));
   assign run_done  = (k_ff + PW'(1)) == hi_ff;
   assign set_done  = (k_ff + PW'(1)) == n_ext;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept && req_last) begin
               state_in = ST_PASS;
            end
         end
         ST_PASS: begin
            state_in = (width_ff >= n_ext) ? ST_EMIT_READ : ST_RUN;
         end
         ST_RUN: begin
            state_in = (lo_ff >= n_ext) ? ST_PASS : ST_READ;
         end
         ST_READ: begin
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            state_in = run_done ? ST_RUN : ST_READ;
         end
         ST_EMIT_READ: begin
            state_in = ST_EMIT_PUT;
         end
         ST_EMIT_PUT: begin
            if (out_free) begin
               state_in = set_done ? ST_LOAD : ST_EMIT_READ;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // counters and run bounds
   always_comb begin
      count_in   = count_ff;
      dropped_in = dropped_ff;
      sel_in     = sel_ff;
      width_in   = width_ff;
      lo_in      = lo_ff;
      mid_in     = mid_ff;
      hi_in      = hi_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (room) begin
                  count_in = count_ff + CW'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               width_in = PW'(1);
               sel_in   = 1'b0;
            end
         end
         ST_PASS: begin
            lo_in = '0;
            k_in  = '0;
         end
         ST_RUN: begin
            if (lo_ff >= n_ext) begin
               width_in = width_ff << 1;
               sel_in   = ~sel_ff;
            end else begin
               mid_in = (lo_w > n_ext) ? n_ext : lo_w;
               hi_in  = (lo_2w > n_ext) ? n_ext : lo_2w;
               i_in   = lo_ff;
               j_in   = (lo_w > n_ext) ? n_ext : lo_w;
               k_in   = lo_ff;
            end
         end
         ST_MERGE: begin
            k_in = k_ff + PW'(1);
            if (take_left) begin
               i_in = i_ff + PW'(1);
            end else begin
               j_in = j_ff + PW'(1);
            end
            if (run_done) begin
               lo_in = lo_2w;
            end
         end
         ST_EMIT_PUT: begin
            if (out_free) begin
               k_in = k_ff + PW'(1);
               if (set_done) begin
                  count_in   = '0;
                  dropped_in = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // outputs
   always_comb begin
      req_stall       = (state_ff != ST_LOAD);
      rd_addr0        = i_ff[AW-1:0];
      rd_addr1        = j_ff[AW-1:0];
      wr_addr         = k_ff[AW-1:0];
      wr_data         = take_left ? rd_left : rd_right;
      ctrl            = '0;
      ctrl.rd_sel_b   = sel_ff;
      ctrl.overflow   = dropped_ff;
      ctrl.end_of_set = set_done;
      case (state_ff)
         ST_LOAD: begin
            wr_addr   = count_ff[AW-1:0];
            wr_data   = req_value;
            ctrl.wr_a = accept && room;
         end
         ST_MERGE: begin
            ctrl.wr_a = sel_ff;
            ctrl.wr_b = ~sel_ff;
         end
         ST_EMIT_READ: begin
            rd_addr0 = k_ff[AW-1:0];
         end
         ST_EMIT_PUT: begin
            rd_addr0  = k_ff[AW-1:0];
            ctrl.emit = out_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
         sel_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
         sel_ff     <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      width_ff <= width_in;
      lo_ff    <= lo_in;
      mid_ff   <= mid_in;
      hi_ff    <= hi_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      k_ff     <= k_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(SIZE))
      else $error("kept word count above capacity");

   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      !(ctrl.wr_a && ctrl.wr_b))
      else $error("both buffers written in one cycle");

   a_merge_in_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE) |-> (k_ff < hi_ff))
      else $error("merge write outside its run");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      ctrl.emit |-> out_free)
      else $error("word emitted into a full output register");

   a_end_to_load: assert property (@(posedge clock) disable iff (reset)
      (ctrl.emit && ctrl.end_of_set) |=> (state_ff == ST_LOAD) && (count_ff == '0))
      else $error("set not closed after its final word");

endmodule

`default_nettype wire

// ===== hdl/bottom_up_merge_sorter.sv =====
// ----------------------------------------------------------------------------
// bottom_up_merge_sorter
// Collects up to SIZE signed words, sorts them stably in ascending order by
// bottom-up merging and emits them with end-of-set and overflow marks.
// ----------------------------------------------------------------------------
// load: one cycle per word, no response until the word marked last
// sort: each merged word passes a READ and a MERGE state through the shared
//    compare and the buffer read ports; RUN opens each run, PASS each pass
// emit: EMIT_READ, EMIT_PUT per word; output register decouples rsp_stall
// one set at a time: no new word is taken until the set is fully emitted
// reset clears sequencer state, count and overflow; buffers are not cleared
`default_nettype none

module bottom_up_merge_sorter
   import bums_pkg::*;
#(
   parameter int SIZE = 32
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_stall,
   input  wire data_type req_value,
   input  wire logic     req_last,
   output logic          rsp_valid,
   input  wire logic     rsp_stall,
   output data_type      rsp_sorted_value,
   output logic          rsp_end_of_set,
   output logic          rsp_overflow
);

   localparam int AW = $clog2(SIZE);

   bums_ctrl_type ctrl;
   logic [AW-1:0] rd_addr0;
   logic [AW-1:0] rd_addr1;
   logic [AW-1:0] wr_addr;
   data_type      wr_data;
   data_type      a_rd0, a_rd1, b_rd0, b_rd1;
   data_type      rd_left, rd_right;
   logic          out_free;

   logic          rsp_valid_ff, rsp_valid_in;
   data_type      rsp_value_ff;
   logic          rsp_end_ff;
   logic          rsp_ovf_ff;

   assign rd_left  = ctrl.rd_sel_b ? b_rd0 : a_rd0;
   assign rd_right = ctrl.rd_sel_b ? b_rd1 : a_rd1;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   bums_ram #(.DEPTH(SIZE)) u_buf_a (
      .clock    (clock),
      .wr_en    (ctrl.wr_a),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr0 (rd_addr0),
      .rd_addr1 (rd_addr1),
      .rd_data0 (a_rd0),
      .rd_data1 (a_rd1)
   );

   bums_ram #(.DEPTH(SIZE)) u_buf_b (
      .clock    (clock),
      .wr_en    (ctrl.wr_b),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr0 (rd_addr0),
      .rd_addr1 (rd_addr1),
      .rd_data0 (b_rd0),
      .rd_data1 (b_rd1)
   );

   bums_sequencer #(.SIZE(SIZE)) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_value (req_value),
      .req_last  (req_last),
      .req_stall (req_stall),
      .out_free  (out_free),
      .rd_left   (rd_left),
      .rd_right  (rd_right),
      .rd_addr0  (rd_addr0),
      .rd_addr1  (rd_addr1),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .ctrl      (ctrl)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.emit) begin
         rsp_value_ff <= rd_left;
         rsp_end_ff   <= ctrl.end_of_set;
         rsp_ovf_ff   <= ctrl.overflow;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_end_of_set   = rsp_end_ff;
   assign rsp_overflow     = rsp_ovf_ff;

endmodule

`default_nettype wire
